>>> hdl/sld_pkg.sv
// Shared constants and types for the sync, length and checksum deframer.
`timescale 1ns / 1ps

package sld_pkg;

  localparam int unsigned MaxFrameBytes = 64;
  localparam int unsigned AddrW         = $clog2(MaxFrameBytes);
  localparam int unsigned CountW        = $clog2(MaxFrameBytes + 1);
  localparam int unsigned FrameOverhead = 4;
  localparam int unsigned LenIndex      = 2;
  localparam int unsigned TimeoutW      = 16;

  localparam logic [7:0]          SyncByte       = 8'h55;
  localparam logic [TimeoutW-1:0] TimeoutDefault = TimeoutW'(50);
  localparam logic [TimeoutW-1:0] IdleMax        = '1;

  // tuser codes on the input side
  localparam logic OpByte = 1'b0;
  localparam logic OpTick = 1'b1;

  typedef enum logic [1:0] {
    EV_BYTE     = 2'd0,
    EV_CHECKSUM = 2'd1,
    EV_OVERFLOW = 2'd2,
    EV_TIMEOUT  = 2'd3
  } sld_event_e;

endpackage

>>> hdl/sync_length_checksum_deframer.sv
// Top level: UART byte deframer with sync hunt, length field and additive checksum.
`timescale 1ns / 1ps

// Usage
//   Input stream (s_axis_*): one beat per received UART byte or per time tick;
//     tuser = 0 means tdata is a received byte, tuser = 1 means one tick.
//   Output stream (m_axis_*): frame bytes (tuser = EV_BYTE) with tlast on the
//     final byte, or single status beats (checksum failure, overflow discard,
//     timeout discard) with tlast set and tdata zero.
//   Config: cfg_we_i loads cfg_wdata_i into the timeout register (idle ticks
//     after the last byte beyond which an open frame is dropped).
// Flow
//   A byte or tick is taken while idle and the output register is free; a status
//     beat shows up on the output the cycle after the beat that caused it.
//   A completed good frame is read back from the 64-entry frame store byte by byte
//     (synchronous read, then load into the output register once it is free), and
//     no input is taken until the whole frame is read out.
// Reset: byte count, running sum and idle counter clear, timeout returns to 50,
//   the output register empties; the frame store is not cleared, only entries
//   written for the current frame are ever read.
// Back-pressure: a single output register holds the pending beat; while it is
//   stalled the input is held off and the readout waits, nothing is dropped.
module sync_length_checksum_deframer
  import sld_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [TimeoutW-1:0] cfg_wdata_i,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] rx_byte
  input  logic                s_axis_tuser,   // [0] operation
  // output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // [7:0] frame_byte
  output logic [1:0]          m_axis_tuser,   // [1:0] event_res
  output logic                m_axis_tlast    // last_of_frame
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_LOAD
  } state_e;

  // frame store, one write port and one registered read port
  logic [7:0] mem_q [MaxFrameBytes];
  logic [7:0] rdata_q;

  state_e              state_q, state_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [7:0]          sum_q, sum_d;
  logic [7:0]          len_q, len_d;
  logic [TimeoutW-1:0] idle_q, idle_d;
  logic [TimeoutW-1:0] timeout_q;
  logic [AddrW-1:0]    raddr_q, raddr_d;

  logic                out_valid_q, out_valid_d;
  sld_event_e          out_event_q, out_event_d;
  logic [7:0]          out_byte_q, out_byte_d;
  logic                out_last_q, out_last_d;

  logic                mem_we;
  logic                out_free;
  logic                in_fire;
  logic [CountW-1:0]   count_inc;
  logic [8:0]          need;
  logic                rd_last;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign count_inc     = count_q + CountW'(1);
  assign need          = {1'b0, len_q} + 9'(FrameOverhead);
  assign rd_last       = (CountW'(raddr_q) + CountW'(1)) == count_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    sum_d       = sum_q;
    len_d       = len_q;
    idle_d      = idle_q;
    raddr_d     = raddr_q;
    mem_we      = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_event_d = out_event_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser == OpTick) begin
            idle_d = (idle_q == IdleMax) ? idle_q : idle_q + TimeoutW'(1);
            if (idle_d > timeout_q && count_q != '0) begin
              count_d     = '0;
              sum_d       = '0;
              out_valid_d = 1'b1;
              out_event_d = EV_TIMEOUT;
              out_byte_d  = '0;
              out_last_d  = 1'b1;
            end
          end else begin
            idle_d = '0;
            if (count_q == '0 && s_axis_tdata != SyncByte) begin
              // hunting for sync: drop the byte
            end else if (count_q >= CountW'(MaxFrameBytes)) begin
              count_d     = '0;
              sum_d       = '0;
              out_valid_d = 1'b1;
              out_event_d = EV_OVERFLOW;
              out_byte_d  = '0;
              out_last_d  = 1'b1;
            end else begin
              mem_we  = 1'b1;
              count_d = count_inc;
              sum_d   = sum_q + s_axis_tdata;
              if (count_q == CountW'(LenIndex)) begin
                len_d = s_axis_tdata;
              end
              // length byte is already held once the count reaches the overhead
              if (count_inc >= CountW'(FrameOverhead) && 9'(count_inc) >= need) begin
                if (sum_q != s_axis_tdata) begin
                  count_d     = '0;
                  sum_d       = '0;
                  out_valid_d = 1'b1;
                  out_event_d = EV_CHECKSUM;
                  out_byte_d  = '0;
                  out_last_d  = 1'b1;
                end else begin
                  raddr_d = '0;
                  state_d = S_RD;
                end
              end
            end
          end
        end
      end
      S_RD: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_event_d = EV_BYTE;
          out_byte_d  = rdata_q;
          out_last_d  = rd_last;
          if (rd_last) begin
            count_d = '0;
            sum_d   = '0;
            state_d = S_IDLE;
          end else begin
            raddr_d = raddr_q + AddrW'(1);
            state_d = S_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      sum_q       <= '0;
      idle_q      <= '0;
      timeout_q   <= TimeoutDefault;
      raddr_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      idle_q      <= idle_d;
      raddr_q     <= raddr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    len_q       <= len_d;
    out_event_q <= out_event_d;
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[count_q[AddrW-1:0]] <= s_axis_tdata;
    end
    if (state_q == S_RD) begin
      rdata_q <= mem_q[raddr_q];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_event_q;
  assign m_axis_tlast  = out_last_q;

endmodule

>>> hdl/sld_checker.sv
// Port-level checker for the deframer, bound to the top level.
`timescale 1ns / 1ps

module sld_checker
  import sld_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // status beats are single-beat frames with zero data
  a_status_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != EV_BYTE |-> m_axis_tlast && m_axis_tdata == 8'h00)
    else $error("status beat without tlast or with nonzero data");

  // input is held off while a result is stuck in the output register
  a_no_accept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input ready while output stalled");

  // out of reset the output register is empty
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind sync_length_checksum_deframer sld_checker u_sld_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

>>> verif/sld_checker.sv
// Self-checking monitor for the sync, length and checksum deframer streams.
`timescale 1ns / 1ps

module sld_monitor
  import sld_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [TimeoutW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] rx_byte
  input  logic                s_axis_tuser,   // [0] operation
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [7:0]          m_axis_tdata,   // [7:0] frame_byte
  input  logic [1:0]          m_axis_tuser,   // [1:0] event_res
  input  logic                m_axis_tlast,
  output int                  fail_count_o,
  output int                  pending_o
);

  typedef struct packed {
    sld_event_e ev;
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  out_beat_t           exp_beats[$];
  logic [7:0]          frame_mem[MaxFrameBytes];
  logic [CountW-1:0]   held_count;
  logic [7:0]          held_sum;
  logic [TimeoutW-1:0] idle_cnt;
  logic [TimeoutW-1:0] timeout_reg;
  int                  fails;

  function automatic void push_exp(sld_event_e ev, logic [7:0] data, logic last);
    out_beat_t b;
    b.ev   = ev;
    b.data = data;
    b.last = last;
    exp_beats.insert(exp_beats.size(), b);
  endfunction

  function automatic void drop_frame();
    held_count = '0;
    held_sum   = '0;
  endfunction

  // Advance the deframer state by one input beat and queue the beats it emits.
  function automatic void deframe_beat(logic op, logic [7:0] b);
    logic [7:0] prev_sum;
    if (op == OpTick) begin
      if (idle_cnt != IdleMax) idle_cnt++;
      if (idle_cnt > timeout_reg && held_count != 0) begin
        drop_frame();
        push_exp(EV_TIMEOUT, 8'h00, 1'b1);
      end
    end else begin
      idle_cnt = '0;
      if (held_count == 0 && b != SyncByte) begin
        // still hunting for sync
      end else if (held_count >= MaxFrameBytes) begin
        // incoming byte is dropped with the held frame, even a sync byte
        drop_frame();
        push_exp(EV_OVERFLOW, 8'h00, 1'b1);
      end else begin
        prev_sum = held_sum;
        frame_mem[held_count[AddrW-1:0]] = b;
        held_count++;
        held_sum += b;
        if (held_count >= FrameOverhead &&
            held_count >= frame_mem[LenIndex] + FrameOverhead) begin
          if (prev_sum != b) begin
            drop_frame();
            push_exp(EV_CHECKSUM, 8'h00, 1'b1);
          end else begin
            for (int i = 0; i < held_count; i++)
              push_exp(EV_BYTE, frame_mem[i], (i + 1 == held_count));
            drop_frame();
          end
        end
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      exp_beats.delete();
      drop_frame();
      idle_cnt    = '0;
      timeout_reg = TimeoutDefault;
      fails       = 0;
    end else begin
      if (cfg_we_i) timeout_reg = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) deframe_beat(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (exp_beats.size() == 0) begin
          $display("%0t: unexpected beat ev=%0d data=%02h last=%b", $time,
                   m_axis_tuser, m_axis_tdata, m_axis_tlast);
          fails++;
        end else begin
          want = exp_beats.pop_front();
          if (m_axis_tuser !== want.ev || m_axis_tdata !== want.data ||
              m_axis_tlast !== want.last) begin
            $display("%0t: mismatch expected ev=%0d data=%02h last=%b, got ev=%0d data=%02h last=%b",
                     $time, want.ev, want.data, want.last,
                     m_axis_tuser, m_axis_tdata, m_axis_tlast);
            fails++;
          end
        end
      end
    end
    fail_count_o = fails;
    pending_o    = exp_beats.size();
  end

endmodule

>>> verif/tb_sync_length_checksum_deframer.sv
// Testbench top: stimulus, back-pressure and verdict for the deframer.
`timescale 1ns / 1ps

module tb_sync_length_checksum_deframer
  import sld_pkg::*;
();

  localparam int HalfPeriod  = 5;
  localparam int ResetCycles = 7;
  localparam int IdleLimit   = 5000;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 2 * MaxFrameBytes + 8;
  localparam int RandBeats   = 6;   // per random phase
  localparam int NumPhases   = 4;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [TimeoutW-1:0] cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;
  logic                s_axis_tuser  = OpByte;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                m_axis_tlast;

  int                  fail_count;
  int                  exp_pending;
  int                  src_idle_pct  = 0;
  int                  snk_stall_pct = 0;
  bit                  hold_req      = 1'b0;
  bit                  hold_done     = 1'b0;
  int                  hold_left     = 0;
  int                  frame_beats   = 0;
  int                  quiet_cycles  = 0;
  logic [TimeoutW-1:0] timeout_now   = TimeoutDefault;

  initial clk_i = 1'b0;
  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  sync_length_checksum_deframer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  sld_monitor frame_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (exp_pending)
  );

  // Receiver: random stalls, plus one long hold-off when requested.
  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Watchdog on cycles with no beat moving on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= IdleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // One input beat; valid stays high into the next call unless a gap is drawn.
  task automatic send_beat(input logic op, input logic [7:0] data);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_tick();
    send_beat(OpTick, 8'($urandom));
    frame_beats++;
  endtask

  // Sync, header byte, length, payload, checksum; optional stray ticks inside.
  task automatic send_frame(input int pay_len, input bit bad_sum, input int tick_pct);
    logic [7:0] seq[$];
    logic [7:0] sum;
    seq.insert(seq.size(), SyncByte);
    seq.insert(seq.size(), ($urandom_range(7) == 0) ? 8'($urandom) : 8'hAA);
    seq.insert(seq.size(), 8'(pay_len));
    repeat (pay_len) seq.insert(seq.size(), 8'($urandom));
    sum = '0;
    foreach (seq[i]) sum += seq[i];
    if (bad_sum) sum ^= 8'($urandom_range(1, 255));
    seq.insert(seq.size(), sum);
    foreach (seq[i]) begin
      if ($urandom_range(99) < tick_pct) send_tick();
      send_beat(OpByte, seq[i]);
    end
    frame_beats += seq.size();
  endtask

  // Length too long to fit: fill the store, then one byte more.
  task automatic send_overflow(input logic [7:0] extra);
    send_beat(OpByte, SyncByte);
    send_beat(OpByte, 8'hAA);
    send_beat(OpByte, 8'($urandom_range(MaxFrameBytes - FrameOverhead + 1, 255)));
    repeat (MaxFrameBytes - 3) send_beat(OpByte, 8'($urandom));
    send_beat(OpByte, extra);
    frame_beats += MaxFrameBytes + 1;
  endtask

  // Open a short frame and let it time out.
  task automatic send_partial();
    int extra;
    extra = $urandom_range(2);
    send_beat(OpByte, SyncByte);
    repeat (extra) send_beat(OpByte, 8'($urandom));
    frame_beats += 1 + extra;
    repeat (int'(timeout_now) + 1) send_tick();
  endtask

  task automatic send_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(1)) begin
        send_tick();
      end else begin
        b = 8'($urandom);
        if (b == SyncByte) b = 8'h00;
        send_beat(OpByte, b);
        frame_beats++;
      end
    end
  endtask

  // Stop offering, wait for every expected beat, then let the block settle.
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (exp_pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_timeout(input logic [TimeoutW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    timeout_now = value;
    @(negedge clk_i);
  endtask

  task automatic run_random(input int n_beats);
    int start;
    int pick;
    start = frame_beats;
    while (frame_beats - start < n_beats) begin
      pick = $urandom_range(99);
      if (pick < 45)
        send_frame(($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(6), 1'b0, 5);
      else if (pick < 60)
        send_frame($urandom_range(6), 1'b1, 5);
      else if (pick < 72 && timeout_now <= 60)
        send_partial();
      else if (pick < 95)
        send_noise();
      else
        send_overflow(8'($urandom));
    end
  endtask

  initial begin
    logic [TimeoutW-1:0] phase_tmo[NumPhases];
    int                  phase_src[NumPhases];
    int                  phase_snk[NumPhases];
    phase_tmo = '{16'd5, 16'hFFFF, 16'd0, TimeoutW'($urandom_range(1, 20))};
    phase_src = '{0, 75, 0, 34};
    phase_snk = '{0, 0, 75, 34};

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: hunting, smallest good frame, bad checksum
    send_beat(OpTick, 8'hFF);
    send_beat(OpByte, 8'h00);
    send_beat(OpByte, 8'hFF);
    send_frame(0, 1'b0, 0);
    send_frame(1, 1'b1, 0);
    // zero timeout: first tick drops an open frame
    quiesce();
    write_timeout('0);
    send_beat(OpByte, SyncByte);
    send_beat(OpTick, 8'h00);
    // maximum timeout: ticks inside a frame are harmless
    quiesce();
    write_timeout('1);
    send_beat(OpByte, SyncByte);
    send_beat(OpByte, 8'hAA);
    repeat (3) send_beat(OpTick, 8'h5A);
    send_beat(OpByte, 8'h00);
    send_beat(OpByte, 8'hFF);
    quiesce();
    write_timeout(TimeoutDefault);

    // back-pressure: output held off while bytes keep coming, then
    // an overflow whose dropped byte is a sync byte
    hold_req = 1'b1;
    send_frame(2, 1'b0, 0);
    send_overflow(SyncByte);
    send_beat(OpByte, 8'h23);
    send_frame(2, 1'b0, 0);

    for (int p = 0; p < NumPhases; p++) begin
      quiesce();
      write_timeout(phase_tmo[p]);
      src_idle_pct  = phase_src[p];
      snk_stall_pct = phase_snk[p];
      run_random(RandBeats);
    end

    quiesce();
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
